// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the wheel power ramp checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define RCW_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcw: same-cycle property failed");

// The consequent holds in the cycle after the antecedent.
`define RCW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcw: next-cycle property failed");

`endif

// File: rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// Types, widths, codes and the cosine table of the wheel power ramp.
// ----------------------------------------------------------------------------
package rcw_pkg;

  localparam int COS_TABLE_ENTRIES = 256;
  localparam int COS_FRAC_BITS     = 15;

  localparam int TIME_W     = 32;
  localparam int DUR_W      = 26;
  localparam int PWR_W      = 7;
  localparam int FP_W       = 8;
  localparam int EL_W       = 24;
  localparam int DIR_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DUR_W;

  // Ramp time that still needs a division is below twice a duration.
  localparam int TW    = DUR_W + 1;
  localparam int QW    = $clog2(2 * COS_TABLE_ENTRIES);
  localparam int DVD_W = TW + $clog2(COS_TABLE_ENTRIES);

  localparam int COS_W    = COS_FRAC_BITS + 1;
  localparam int COS_HALF = COS_TABLE_ENTRIES / 2;
  localparam int K_W      = $clog2(COS_HALF + 1);

  localparam int W_W   = COS_FRAC_BITS + 2;
  localparam int AMP_W = PWR_W - 1;
  localparam int ACC_W = COS_FRAC_BITS + PWR_W + 2;

  localparam longint unsigned PI_Q28  = 64'd843314857;
  localparam longint          ONE_Q28 = 64'sd268435456;

  // Denominators (2i-1)*2i of the Taylor terms of the cosine, i = 1 to 9.
  localparam longint unsigned TAYLOR_DEN [9] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };

  typedef enum logic {
    OP_RUN     = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_STRAIGHT  = 4'd0,
    DIR_RIGHT     = 4'd1,
    DIR_LEFT      = 4'd2,
    DIR_STOP      = 4'd3,
    DIR_BACK      = 4'd4,
    DIR_BACKRIGHT = 4'd5,
    DIR_BACKLEFT  = 4'd6,
    DIR_CW        = 4'd7,
    DIR_CCW       = 4'd8
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRAIGHT_RAMP = 3'd0,
    CFG_CURVE_HALF    = 3'd1,
    CFG_START_POWER   = 3'd2,
    CFG_CURVE_MIN     = 3'd3,
    CFG_MAX_POWER     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DUR_W-1:0]   divisor;
  } rcw_div_req_t;

  typedef struct packed {
    logic            done;
    logic [QW-1:0]   quo;
  } rcw_div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [W_W-1:0]     weight;
    logic [AMP_W-1:0]   amp_mag;
    logic               amp_neg;
    logic [PWR_W-1:0]   base;
  } rcw_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [PWR_W-1:0]   power;
  } rcw_mul_rsp_t;

  typedef logic [COS_W-1:0] cos_lut_t [COS_HALF+1];

  // Rounded cosine magnitude of pi*k/N, k in the first quarter, from a Q28
  // Taylor series with truncated products.
  function automatic logic [COS_W-1:0] cos_mag(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    x    = (PI_Q28 * longint'(k)) >> $clog2(COS_TABLE_ENTRIES);
    x2   = (x * x) >> 28;
    term = ONE_Q28;
    sum  = ONE_Q28;
    for (int i = 1; i <= 9; i++) begin
      term = ((term * x2) >> 28) / TAYLOR_DEN[i-1];
      if ((i % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q28) begin
      sum = ONE_Q28;
    end
    r = (longint'(sum) + (64'd1 << (27 - COS_FRAC_BITS))) >> (28 - COS_FRAC_BITS);
    return r[COS_W-1:0];
  endfunction

  function automatic cos_lut_t build_cos_lut();
    cos_lut_t lut;
    for (int k = 0; k <= COS_HALF; k++) begin
      lut[k] = cos_mag(k);
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT = build_cos_lut();

endpackage

// File: rtl/raised_cosine_wheel_power_ramp_core.sv
// ----------------------------------------------------------------------------
// raised_cosine_wheel_power_ramp_core
// Left and right wheel powers per control tick, with raised-cosine ramps.
// ----------------------------------------------------------------------------
// One request is worked at a time, and for straight and right requests ramp
// time accumulates at the edge that accepts it. Fixed directions go from
// acceptance to the result state. A ramp first compares the accumulated time
// against the ramp length, and one that has already finished then goes to the
// result state. A running ramp passes the bit-serial divider (one quotient bit
// per cycle, log2 of twice the table size in all, and a handover of the
// quotient), the cosine table, the forming of the weight and the shift-and-add
// weighting (one bit per cycle for the 6 amplitude bits, and a handover of the
// sum) before the result state, which loads the output register. The next
// request is taken while a result waits at the output.
// A restart request clears the accumulated time and yields no result.
module raised_cosine_wheel_power_ramp_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcw_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [rcw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [rcw_pkg::DIR_W-1:0]        direction_i,
  input  logic signed [rcw_pkg::FP_W-1:0]  forward_power_i,
  input  logic [rcw_pkg::EL_W-1:0]         elapsed_us_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [rcw_pkg::FP_W-1:0]  left_power_o,
  output logic signed [rcw_pkg::FP_W-1:0]  right_power_o
);
  import rcw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FOLD,
    ST_WGT,
    ST_MUL,
    ST_RESULT
  } state_e;

  state_e              state_q;
  logic [DUR_W-1:0]    straight_q;
  logic [DUR_W-1:0]    curve_half_q;
  logic [PWR_W-1:0]    start_pwr_q;
  logic [PWR_W-1:0]    curve_min_q;
  logic [PWR_W-1:0]    max_pwr_q;
  logic [TIME_W-1:0]   time_sum_q;
  logic                started_q;
  logic                curve_q;
  logic signed [FP_W-1:0] fwd_q;
  logic [FP_W-1:0]     res_left_q;
  logic [FP_W-1:0]     res_right_q;
  logic [COS_W-1:0]    cos_mag_q;
  logic                cos_neg_q;
  logic                out_valid_q;
  logic [FP_W-1:0]     out_left_q;
  logic [FP_W-1:0]     out_right_q;

  logic                in_acc;
  logic [TIME_W:0]     t_sum;
  logic [TIME_W-1:0]   t_next;
  logic                ramp_done;
  logic [FP_W-1:0]     f_neg;
  logic [FP_W-1:0]     max_ext;
  logic [QW-1:0]       k_unfold;
  logic [QW-1:0]       k_fold;
  logic                k_neg;
  logic                plus;
  logic [W_W-1:0]      weight;
  logic [PWR_W-1:0]    base;
  logic signed [PWR_W:0] amp_diff;
  logic [PWR_W:0]      amp_abs;
  rcw_div_req_t        div_req;
  rcw_div_rsp_t        div_rsp;
  rcw_mul_req_t        mul_req;
  rcw_mul_rsp_t        mul_rsp;

  function automatic logic [FP_W-1:0] neg_sat(logic signed [FP_W-1:0] v);
    logic [FP_W-1:0] r;
    if (v == {1'b1, {(FP_W-1){1'b0}}}) begin
      r = {1'b0, {(FP_W-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Accumulated time saturates at the top of the 32-bit range.
  assign t_sum  = {1'b0, time_sum_q} + (TIME_W+1)'(elapsed_us_i);
  assign t_next = !started_q ? '0 : (t_sum[TIME_W] ? '1 : t_sum[TIME_W-1:0]);

  assign ramp_done = curve_q ? (time_sum_q >= TIME_W'({curve_half_q, 1'b0}))
                             : (time_sum_q >= TIME_W'(straight_q));
  assign f_neg   = neg_sat(forward_power_i);
  assign max_ext = FP_W'(max_pwr_q);

  // The dip runs past the table end and comes back; then fold to a quarter.
  always_comb begin
    k_unfold = div_rsp.quo;
    if (div_rsp.quo > QW'(COS_TABLE_ENTRIES)) begin
      k_unfold = QW'((QW+1)'(2 * COS_TABLE_ENTRIES) - {1'b0, div_rsp.quo});
    end
    k_neg  = {k_unfold, 1'b0} > (QW+1)'(COS_TABLE_ENTRIES);
    k_fold = k_neg ? (QW'(COS_TABLE_ENTRIES) - k_unfold) : k_unfold;
  end

  // Straight uses 1 - cos and the dip 1 + cos.
  assign plus     = cos_neg_q ^ curve_q;
  assign weight   = plus ? (W_W'(1) << COS_FRAC_BITS) + W_W'(cos_mag_q)
                         : (W_W'(1) << COS_FRAC_BITS) - W_W'(cos_mag_q);
  assign base     = curve_q ? curve_min_q : start_pwr_q;
  assign amp_diff = $signed({1'b0, max_pwr_q}) - $signed({1'b0, base});
  assign amp_abs  = amp_diff[PWR_W] ? (-amp_diff) : amp_diff;

  assign div_req.start    = (state_q == ST_CHECK) && !ramp_done;
  assign div_req.dividend = DVD_W'(time_sum_q[TW-1:0]) * DVD_W'(COS_TABLE_ENTRIES);
  assign div_req.divisor  = curve_q ? curve_half_q : straight_q;

  assign mul_req.start   = (state_q == ST_WGT);
  assign mul_req.weight  = weight;
  assign mul_req.amp_mag = amp_abs[AMP_W:1];
  assign mul_req.amp_neg = amp_diff[PWR_W];
  assign mul_req.base    = base;

  rcw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rcw_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      straight_q   <= DUR_W'(1500000);
      curve_half_q <= DUR_W'(2150000);
      start_pwr_q  <= PWR_W'(5);
      curve_min_q  <= PWR_W'(55);
      max_pwr_q    <= PWR_W'(100);
      time_sum_q   <= '0;
      started_q    <= 1'b0;
      curve_q      <= 1'b0;
      fwd_q        <= '0;
      res_left_q   <= '0;
      res_right_q  <= '0;
      cos_mag_q    <= '0;
      cos_neg_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_left_q   <= '0;
      out_right_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_STRAIGHT_RAMP: straight_q   <= cfg_wdata_i[DUR_W-1:0];
          CFG_CURVE_HALF:    curve_half_q <= cfg_wdata_i[DUR_W-1:0];
          CFG_START_POWER:   start_pwr_q  <= cfg_wdata_i[PWR_W-1:0];
          CFG_CURVE_MIN:     curve_min_q  <= cfg_wdata_i[PWR_W-1:0];
          CFG_MAX_POWER:     max_pwr_q    <= cfg_wdata_i[PWR_W-1:0];
          default: ;
        endcase
      end

      // A waiting result that is taken while the next one is ready is
      // replaced below, so the flag only drops outside the result state.
      if (out_valid_q && out_ready_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_e'(op_i) == OP_RESTART) begin
              time_sum_q <= '0;
              started_q  <= 1'b0;
            end else begin
              fwd_q <= forward_power_i;
              case (dir_e'(direction_i))
                DIR_STRAIGHT, DIR_RIGHT: begin
                  time_sum_q <= t_next;
                  started_q  <= 1'b1;
                  curve_q    <= (dir_e'(direction_i) == DIR_RIGHT);
                  state_q    <= ST_CHECK;
                end
                DIR_LEFT: begin
                  res_right_q <= forward_power_i;
                  res_left_q  <= '0;
                  state_q     <= ST_RESULT;
                end
                DIR_STOP: begin
                  res_right_q <= '0;
                  res_left_q  <= '0;
                  state_q     <= ST_RESULT;
                end
                DIR_BACKRIGHT: begin
                  res_right_q <= f_neg;
                  res_left_q  <= '0;
                  state_q     <= ST_RESULT;
                end
                DIR_BACKLEFT: begin
                  res_right_q <= '0;
                  res_left_q  <= f_neg;
                  state_q     <= ST_RESULT;
                end
                DIR_CW: begin
                  res_right_q <= f_neg;
                  res_left_q  <= forward_power_i;
                  state_q     <= ST_RESULT;
                end
                DIR_CCW: begin
                  res_right_q <= forward_power_i;
                  res_left_q  <= f_neg;
                  state_q     <= ST_RESULT;
                end
                default: begin
                  res_right_q <= forward_power_i;
                  res_left_q  <= forward_power_i;
                  state_q     <= ST_RESULT;
                end
              endcase
            end
          end
        end
        ST_CHECK: begin
          if (ramp_done) begin
            res_right_q <= max_ext;
            res_left_q  <= curve_q ? fwd_q : max_ext;
            state_q     <= ST_RESULT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          cos_mag_q <= COS_LUT[k_fold[K_W-1:0]];
          cos_neg_q <= k_neg;
          state_q   <= ST_WGT;
        end
        ST_WGT: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            res_right_q <= FP_W'(mul_rsp.power);
            res_left_q  <= curve_q ? fwd_q : FP_W'(mul_rsp.power);
            state_q     <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_left_q  <= res_left_q;
            out_right_q <= res_right_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_power_o  = out_left_q;
  assign right_power_o = out_right_q;

endmodule

// File: rtl/rcw_div.sv
// ----------------------------------------------------------------------------
// rcw_div
// Restoring divider that produces one quotient bit per clock.
// ----------------------------------------------------------------------------
module rcw_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcw_pkg::rcw_div_req_t req_i,
  output rcw_pkg::rcw_div_rsp_t rsp_o
);
  import rcw_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DUR_W-1:0] rem_q;
  logic [DUR_W-1:0] dvs_q;
  logic [QW-1:0]    sh_q;

  logic [DUR_W:0]   trial;
  logic             ge;
  logic [DUR_W:0]   diff;

  // The upper dividend part is below the divisor, so the remainder never
  // needs more than the divisor's width.
  assign trial = {rem_q, sh_q[QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
        rem_q  <= req_i.dividend[DVD_W-1:QW];
        sh_q   <= req_i.dividend[QW-1:0];
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
        sh_q  <= {sh_q[QW-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = sh_q;

endmodule

// File: rtl/rcw_mul.sv
// ----------------------------------------------------------------------------
// rcw_mul
// Shift-and-add weighting of the cosine term, one amplitude bit per clock.
// ----------------------------------------------------------------------------
module rcw_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcw_pkg::rcw_mul_req_t req_i,
  output rcw_pkg::rcw_mul_rsp_t rsp_o
);
  import rcw_pkg::*;

  localparam int CNT_W = $clog2(AMP_W + 1);
  localparam int WS_W  = W_W + AMP_W - 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc_q;
  logic [WS_W-1:0]  wsh_q;
  logic [AMP_W-1:0] amp_q;
  logic             neg_q;

  logic [ACC_W-1:0] addend;

  assign addend = ACC_W'(wsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      wsh_q  <= '0;
      amp_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(AMP_W);
        acc_q  <= ACC_W'(req_i.base) << COS_FRAC_BITS;
        wsh_q  <= WS_W'(req_i.weight);
        amp_q  <= req_i.amp_mag;
        neg_q  <= req_i.amp_neg;
      end else if (busy_q) begin
        if (amp_q[0]) begin
          acc_q <= neg_q ? (acc_q - addend) : (acc_q + addend);
        end
        wsh_q <= {wsh_q[WS_W-2:0], 1'b0};
        amp_q <= {1'b0, amp_q[AMP_W-1:1]};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A negative sum clamps to zero before the fraction is dropped.
  assign rsp_o.done  = done_q;
  assign rsp_o.power = acc_q[ACC_W-1] ? '0 : acc_q[COS_FRAC_BITS +: PWR_W];

endmodule

// File: rtl/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_checker
// Port-level properties of the wheel power ramp, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcw_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  logic                             op_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  logic signed [rcw_pkg::FP_W-1:0]  left_power_o,
  input  logic signed [rcw_pkg::FP_W-1:0]  right_power_o
);
  import rcw_pkg::*;

  // A tick that produces a result keeps the block busy in the next cycle.
  `RCW_ASSERT_NEXT(a_run_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o && (op_i != OP_RESTART), !in_ready_o)

  // A restart never creates a result of its own.
  `RCW_ASSERT_NEXT(a_restart_silent, clk_i, rst_ni, in_valid_i && in_ready_o && (op_i == OP_RESTART) && !out_valid_o, !out_valid_o)

  // A result only appears straight after the block was working.
  `RCW_ASSERT_SAME(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))

  `RCW_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(left_power_o) && $stable(right_power_o))

endmodule

bind raised_cosine_wheel_power_ramp_core rcw_checker u_rcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .op_i          (op_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .left_power_o  (left_power_o),
  .right_power_o (right_power_o)
);
